### sv/npt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npt_pkg
// Shared constants, codes and types for the nearest point time lookup block.
// ----------------------------------------------------------------------------
package npt_pkg;

  // table geometry
  localparam int unsigned MAX_SAMPLES = 1024;
  localparam int unsigned IDX_W       = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1);

  // field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned POS_W    = 24;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MIDX_W   = 10;

  // distance datapath widths: |d| fits POS_W+1 bits, d^2 fits 2*POS_W+1
  localparam int unsigned ABS_W  = POS_W + 1;
  localparam int unsigned SQ_W   = 2 * POS_W + 1;
  localparam int unsigned DIST_W = SQ_W + 1;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // one stored sample
  typedef struct packed {
    logic        [TIME_W-1:0] time_us;
    logic signed [POS_W-1:0]  y;
    logic signed [POS_W-1:0]  x;
  } sample_t;

  // sideband that travels with a sample through the distance unit
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] time_us;
  } tag_t;

endpackage
`default_nettype wire

### sv/npt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npt_if
// Request and result channels of the nearest point time lookup block.
// ----------------------------------------------------------------------------
interface npt_in_if;
  logic                                    valid;
  logic                                    ready;
  logic        [npt_pkg::KIND_W-1:0]       kind;
  logic signed [npt_pkg::POS_W-1:0]        pos_x;
  logic signed [npt_pkg::POS_W-1:0]        pos_y;
  logic        [npt_pkg::TIME_W-1:0]       sample_time;

  modport source (output valid, kind, pos_x, pos_y, sample_time, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, sample_time, output ready);
endinterface

interface npt_out_if;
  logic                              valid;
  logic                              ready;
  logic [npt_pkg::STATUS_W-1:0]      status;
  logic [npt_pkg::TIME_W-1:0]        match_time;
  logic [npt_pkg::MIDX_W-1:0]        match_index;

  modport source (output valid, status, match_time, match_index, input ready);
  modport sink   (input valid, status, match_time, match_index, output ready);
endinterface
`default_nettype wire

### sv/npt_dist_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npt_dist_unit
// Pipelined squared distance unit, one sample per cycle, three stages.
// ----------------------------------------------------------------------------
module npt_dist_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  input  wire npt_pkg::tag_t                       tag_i,
  input  wire logic signed [npt_pkg::POS_W-1:0]    smp_x_i,
  input  wire logic signed [npt_pkg::POS_W-1:0]    smp_y_i,
  input  wire logic signed [npt_pkg::POS_W-1:0]    qry_x_i,
  input  wire logic signed [npt_pkg::POS_W-1:0]    qry_y_i,
  output logic                                     valid_o,
  output npt_pkg::tag_t                            tag_o,
  output logic [npt_pkg::DIST_W-1:0]               dist_o
);

  logic signed [npt_pkg::ABS_W-1:0] dx, dy;
  logic [npt_pkg::ABS_W-1:0]        ax_d, ay_d;
  logic [npt_pkg::ABS_W-1:0]        ax_q, ay_q;
  logic [2*npt_pkg::ABS_W-1:0]      prod_x, prod_y;
  logic [npt_pkg::SQ_W-1:0]         sqx_q, sqy_q;
  logic [npt_pkg::DIST_W-1:0]       dist_q;
  logic [2:0]                       vld_q;
  npt_pkg::tag_t                    tag1_q, tag2_q, tag3_q;

  // stage 1: signed differences and magnitudes
  always_comb begin
    dx   = {smp_x_i[npt_pkg::POS_W-1], smp_x_i} - {qry_x_i[npt_pkg::POS_W-1], qry_x_i};
    dy   = {smp_y_i[npt_pkg::POS_W-1], smp_y_i} - {qry_y_i[npt_pkg::POS_W-1], qry_y_i};
    ax_d = dx[npt_pkg::ABS_W-1] ? npt_pkg::ABS_W'(-dx) : npt_pkg::ABS_W'(dx);
    ay_d = dy[npt_pkg::ABS_W-1] ? npt_pkg::ABS_W'(-dy) : npt_pkg::ABS_W'(dy);
  end

  // stage 2: squares
  assign prod_x = ax_q * ax_q;
  assign prod_y = ay_q * ay_q;

  always_ff @(posedge clk_i) begin
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    sqx_q  <= prod_x[npt_pkg::SQ_W-1:0];
    sqy_q  <= prod_y[npt_pkg::SQ_W-1:0];
    // stage 3: sum of squares
    dist_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
    tag1_q <= tag_i;
    tag2_q <= tag1_q;
    tag3_q <= tag2_q;
  end

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign valid_o = vld_q[2];
  assign tag_o   = tag3_q;
  assign dist_o  = dist_q;

endmodule
`default_nettype wire

### sv/nearest_point_time_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_point_time_lookup
// Trajectory sample table with a nearest point search that returns the time
// and index of the closest stored sample.
// ----------------------------------------------------------------------------
// A clear or append request gives its result in the cycle after acceptance.
// A query on a table of N samples reads all N entries (a full table holds
// 1024): the sample memory has one read port, so the scan
// reads one entry a cycle into a three stage squared distance unit, then a
// compare stage and a result stage follow. The block takes no new request
// during a query. Ties go to the lowest index; an empty table answers with
// the empty status. Requests are taken while a result waits only if that
// result is taken in the same cycle.
// ----------------------------------------------------------------------------
module nearest_point_time_lookup (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  npt_in_if.sink      req_i,
  npt_out_if.source   rsp_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0]                       state_q, state_d;
  logic [npt_pkg::CNT_W-1:0]        count_q;
  logic [npt_pkg::CNT_W-1:0]        rd_cnt_q;
  logic                             accept, take, out_free, issue, table_full;
  logic                             rd_valid_q;
  logic [npt_pkg::IDX_W-1:0]        rd_idx_q, last_idx;
  npt_pkg::sample_t                 mem [npt_pkg::MAX_SAMPLES];
  npt_pkg::sample_t                 rd_data_q;
  logic signed [npt_pkg::POS_W-1:0] qx_q, qy_q;

  npt_pkg::tag_t                    du_tag_in, du_tag;
  logic                             du_valid;
  logic [npt_pkg::DIST_W-1:0]       du_dist;
  logic                             better, scan_last;

  logic [npt_pkg::DIST_W-1:0]       best_dist_q;
  logic [npt_pkg::IDX_W-1:0]        best_idx_q;
  logic [npt_pkg::TIME_W-1:0]       best_time_q;

  logic                             out_valid_q, out_load;
  logic [npt_pkg::STATUS_W-1:0]     out_status_q, out_status_d;
  logic [npt_pkg::TIME_W-1:0]       out_time_q, out_time_d;
  logic [npt_pkg::MIDX_W-1:0]       out_idx_q, out_idx_d;

  // handshakes
  assign take        = out_valid_q && rsp_o.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept      = req_i.valid && req_i.ready;
  assign table_full  = (count_q == npt_pkg::CNT_W'(npt_pkg::MAX_SAMPLES));

  // scan issue and end of scan
  assign issue     = (state_q == ST_SCAN) && (rd_cnt_q != count_q);
  assign last_idx  = npt_pkg::IDX_W'(count_q - npt_pkg::CNT_W'(1));
  assign scan_last = du_valid && (du_tag.idx == last_idx);
  assign better    = (du_tag.idx == '0) || (du_dist < best_dist_q);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && req_i.kind == npt_pkg::KIND_QUERY && count_q != '0) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result payload selection
  always_comb begin
    out_load     = 1'b0;
    out_status_d = npt_pkg::STATUS_OK;
    out_time_d   = '0;
    out_idx_d    = '0;
    if (state_q == ST_RESP) begin
      out_load   = out_free;
      out_time_d = best_time_q;
      out_idx_d  = npt_pkg::MIDX_W'(best_idx_q);
    end else if (accept) begin
      case (req_i.kind)
        npt_pkg::KIND_APPEND: begin
          out_load = 1'b1;
          if (table_full) begin
            out_status_d = npt_pkg::STATUS_FULL;
          end
        end
        npt_pkg::KIND_QUERY: begin
          out_load = (count_q == '0);
          out_status_d = npt_pkg::STATUS_EMPTY;
        end
        default: out_load = 1'b1;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_cnt_q    <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= issue;
      if (accept && req_i.kind == npt_pkg::KIND_CLEAR) begin
        count_q <= '0;
      end else if (accept && req_i.kind == npt_pkg::KIND_APPEND && !table_full) begin
        count_q <= count_q + npt_pkg::CNT_W'(1);
      end
      if (accept) begin
        rd_cnt_q <= '0;
      end else if (issue) begin
        rd_cnt_q <= rd_cnt_q + npt_pkg::CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sample memory: append writes, scan reads
  always_ff @(posedge clk_i) begin
    if (accept && req_i.kind == npt_pkg::KIND_APPEND && !table_full) begin
      mem[count_q[npt_pkg::IDX_W-1:0]] <= '{time_us: req_i.sample_time,
                                           y: req_i.pos_y, x: req_i.pos_x};
    end
    if (issue) begin
      rd_data_q <= mem[rd_cnt_q[npt_pkg::IDX_W-1:0]];
      rd_idx_q  <= rd_cnt_q[npt_pkg::IDX_W-1:0];
    end
  end

  // query point, best candidate and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      qx_q <= req_i.pos_x;
      qy_q <= req_i.pos_y;
    end
    if (du_valid && better) begin
      best_dist_q <= du_dist;
      best_idx_q  <= du_tag.idx;
      best_time_q <= du_tag.time_us;
    end
    if (out_load) begin
      out_status_q <= out_status_d;
      out_time_q   <= out_time_d;
      out_idx_q    <= out_idx_d;
    end
  end

  // shared distance unit
  assign du_tag_in = '{idx: rd_idx_q, time_us: rd_data_q.time_us};

  npt_dist_unit u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_valid_q),
    .tag_i   (du_tag_in),
    .smp_x_i (rd_data_q.x),
    .smp_y_i (rd_data_q.y),
    .qry_x_i (qx_q),
    .qry_y_i (qy_q),
    .valid_o (du_valid),
    .tag_o   (du_tag),
    .dist_o  (du_dist)
  );

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.match_time  = out_time_q;
  assign rsp_o.match_index = out_idx_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= npt_pkg::CNT_W'(npt_pkg::MAX_SAMPLES))
    else $error("sample count beyond table depth");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> rd_cnt_q <= count_q)
    else $error("scan pointer past fill level");

  a_no_req_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !req_i.ready)
    else $error("request taken during a query");

  a_scan_to_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && scan_last |=> state_q == ST_RESP)
    else $error("scan end missed");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != npt_pkg::STATUS_OK |->
      out_time_q == '0 && out_idx_q == '0)
    else $error("nonzero match fields on a failed request");

endmodule
`default_nettype wire
